>>> rtl/lsh_pkg.sv
// Shared package for the limit-switch homing sequencer.
// Holds phase and command codes, field widths and parameter defaults.
// No dependencies.
package lsh_pkg;

   // parameter defaults
   localparam int POSITION_BITS_DEF = 32;
   localparam int TIMER_BITS_DEF    = 20;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int PHASE_W  = 3;
   localparam int AXPOS_W  = 32;
   localparam int LENGTH_W = 31;

   // half period after reset, in ticks
   localparam int HALF_RESET = 500;

   // commands
   localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CALIBRATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HOME_ONLY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FIND_END  = 2'd3;

   // sequencer phases
   localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SEEK_HOME = 3'd1;
   localparam logic [PHASE_W-1:0] PH_BACK_OFF  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_SEEK_END  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DONE      = 3'd4;

   // one input beat
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             home_sensor;
      logic             end_sensor;
   } req_item_type;

   // one result beat
   typedef struct packed {
      logic                      step_pulse;
      logic                      move_direction;
      logic signed [AXPOS_W-1:0] axis_position;
      logic [LENGTH_W-1:0]       axis_length;
      logic [PHASE_W-1:0]        phase;
   } rsp_item_type;

endpackage

>>> rtl/lsh_ifs.sv
// Valid/ready channel interfaces for the homing sequencer.
// Depends on lsh_pkg for field widths.
interface lsh_req_if import lsh_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic             home_sensor;
   logic             end_sensor;

   modport source (output valid, command, home_sensor, end_sensor, input ready);
   modport sink   (input valid, command, home_sensor, end_sensor, output ready);
endinterface

interface lsh_rsp_if import lsh_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      step_pulse;
   logic                      move_direction;
   logic signed [AXPOS_W-1:0] axis_position;
   logic [LENGTH_W-1:0]       axis_length;
   logic [PHASE_W-1:0]        phase;

   modport source (output valid, step_pulse, move_direction, axis_position, axis_length,
                   phase, input ready);
   modport sink   (input valid, step_pulse, move_direction, axis_position, axis_length,
                   phase, output ready);
endinterface

>>> rtl/lsh_in_stage.sv
// Input register of the sequencer: captures one request beat.
// Depends on lsh_pkg.
module lsh_in_stage import lsh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic         drain,
   input  req_item_type item_in,
   output logic         valid_out,
   output req_item_type item_out
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // occupancy: a load refills, a drain alone empties
   always_comb begin
      valid_in = load ? 1'b1 : (drain ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign valid_out = valid_ff;
   assign item_out  = item_ff;

endmodule

>>> rtl/lsh_core.sv
// Sequencer state and single-tick update for the homing sequencer.
// Holds phase, position, length, step timer and the half-period register.
// Depends on lsh_pkg.
module lsh_core import lsh_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int TIMER_BITS    = TIMER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [TIMER_BITS-1:0] csr_wdata,
   input  logic                  fire,
   input  req_item_type          item,
   output rsp_item_type          result
);

   localparam int PB  = POSITION_BITS;
   localparam int TB  = TIMER_BITS;
   localparam int EXT = 64;

   localparam logic signed [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};
   localparam logic signed [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};

   logic [TB-1:0]          half_ff;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic signed [PB-1:0]   pos_ff, pos_in;
   logic [LENGTH_W-1:0]    len_ff, len_in;
   logic [TB:0]            timer_ff, timer_in;
   logic                   then_end_ff, then_end_in;
   logic                   dir_ff, dir_in;

   logic [TB-1:0]          half_eff;
   logic                   busy, home_hit, end_hit, stop, pulse, step_end;
   logic [TB+1:0]          timer_inc;
   logic [TB+1:0]          full_period;
   logic [EXT-1:0]         pos_ext, pos_in_ext;
   logic [LENGTH_W-1:0]    len_clip;

   // half-period register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= TB'(HALF_RESET);
      end else if (csr_we) begin
         half_ff <= csr_wdata;
      end
   end

   // a zero half period acts as one tick
   assign half_eff    = (half_ff == '0) ? TB'(1) : half_ff;
   assign full_period = {1'b0, half_eff, 1'b0};
   assign timer_inc   = {1'b0, timer_ff} + (TB+2)'(1);
   assign step_end    = (timer_inc >= full_period);

   assign busy     = (phase_ff == PH_SEEK_HOME) || (phase_ff == PH_BACK_OFF) ||
                     (phase_ff == PH_SEEK_END);
   assign home_hit = ~item.home_sensor;
   assign end_hit  = ~item.end_sensor;

   // length seen at the current position, clipped to the field range
   assign pos_ext  = {{(EXT-PB){pos_ff[PB-1]}}, pos_ff};
   always_comb begin
      if (pos_ext[EXT-1]) begin
         len_clip = '0;
      end else if (|pos_ext[EXT-2:LENGTH_W]) begin
         len_clip = '1;
      end else begin
         len_clip = pos_ext[LENGTH_W-1:0];
      end
   end

   // one tick of the sequencer
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      timer_in    = timer_ff;
      then_end_in = then_end_ff;
      dir_in      = dir_ff;
      stop        = 1'b0;
      pulse       = 1'b0;
      priority if (!busy && item.command != CMD_TICK) begin
         // start a job
         timer_in = '0;
         if (item.command == CMD_FIND_END) begin
            phase_in = PH_SEEK_END;
            dir_in   = 1'b1;
         end else begin
            then_end_in = (item.command == CMD_CALIBRATE);
            phase_in    = PH_SEEK_HOME;
            dir_in      = 1'b0;
         end
      end else if (busy) begin
         // sensor check where a new step would begin
         if (timer_ff == '0) begin
            priority if (phase_ff == PH_SEEK_HOME && home_hit) begin
               phase_in = PH_BACK_OFF;
               dir_in   = 1'b1;
               stop     = 1'b1;
            end else if (phase_ff == PH_BACK_OFF && !home_hit) begin
               pos_in = '0;
               if (then_end_ff) begin
                  phase_in = PH_SEEK_END;
                  dir_in   = 1'b1;
               end else begin
                  phase_in = PH_DONE;
               end
               stop = 1'b1;
            end else if (phase_ff == PH_SEEK_END && end_hit) begin
               len_in   = len_clip;
               phase_in = PH_DONE;
               stop     = 1'b1;
            end else begin
               stop = 1'b0;
            end
         end
         // step generation, position moves on the last tick of a step
         if (!stop) begin
            pulse = (timer_ff < {1'b0, half_eff});
            if (step_end) begin
               timer_in = '0;
               if (dir_ff) begin
                  if (pos_ff != POS_MAX) pos_in = pos_ff + PB'(1);
               end else begin
                  if (pos_ff != POS_MIN) pos_in = pos_ff - PB'(1);
               end
            end else begin
               timer_in = timer_inc[TB:0];
            end
         end
      end else if (phase_ff > PH_DONE) begin
         phase_in = PH_IDLE;
      end else begin
         phase_in = phase_ff;
      end
   end

   // state registers, advanced once per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         pos_ff      <= '0;
         len_ff      <= '0;
         timer_ff    <= '0;
         then_end_ff <= 1'b0;
         dir_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         timer_ff    <= timer_in;
         then_end_ff <= then_end_in;
         dir_ff      <= dir_in;
      end
   end

   // result shows the state after this tick
   assign pos_in_ext = {{(EXT-PB){pos_in[PB-1]}}, pos_in};
   always_comb begin
      result.step_pulse     = pulse;
      result.move_direction = dir_in;
      result.axis_position  = pos_in_ext[AXPOS_W-1:0];
      result.axis_length    = len_in;
      result.phase          = phase_in;
   end

endmodule

>>> rtl/lsh_out_stage.sv
// Result register of the sequencer: holds one response beat until taken.
// Depends on lsh_pkg.
module lsh_out_stage import lsh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic         taken,
   input  rsp_item_type item_in,
   output logic         valid_out,
   output rsp_item_type item_out
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // occupancy
   always_comb begin
      valid_in = load ? 1'b1 : (taken ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign valid_out = valid_ff;
   assign item_out  = item_ff;

endmodule

>>> rtl/limit_switch_homing_sequencer_top.sv
// Top level of the limit-switch homing sequencer.
// Depends on lsh_pkg, lsh_ifs, lsh_in_stage, lsh_core and lsh_out_stage.
//
// Each request beat is one timing tick (or a start command) for a stepper axis
// homing sequencer; every beat yields exactly one response beat that shows the
// step level for that tick and the direction, position, length and phase after
// it. The block takes one beat per clock cycle while the response side accepts:
// the beat is captured in an input register, the sequencer state is updated in
// combinational logic, and the result lands in an output register. The state
// update finishes every tick before the next beat is taken.
// Backpressure on the response side stalls the input within the cycle.
// csr_wdata sets the half step period in ticks (zero acts as one); write it
// only while the sequencer is idle.
module limit_switch_homing_sequencer_top import lsh_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int TIMER_BITS    = TIMER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   lsh_req_if.sink               req_chan,
   lsh_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [TIMER_BITS-1:0] csr_wdata
);

   req_item_type req_item, s1_item;
   rsp_item_type core_result, rsp_item;
   logic         s1_valid, rsp_valid, fire, out_free, req_fire;

   // handshake: the core fires when the input register holds a beat and the
   // output register is free or being emptied
   assign out_free = !rsp_valid || rsp_chan.ready;
   assign fire     = s1_valid && out_free;
   assign req_chan.ready = !s1_valid || fire;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign req_item.command     = req_chan.command;
   assign req_item.home_sensor = req_chan.home_sensor;
   assign req_item.end_sensor  = req_chan.end_sensor;

   lsh_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .drain     (fire),
      .item_in   (req_item),
      .valid_out (s1_valid),
      .item_out  (s1_item)
   );

   lsh_core #(
      .POSITION_BITS (POSITION_BITS),
      .TIMER_BITS    (TIMER_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (s1_item),
      .result    (core_result)
   );

   lsh_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .taken     (rsp_chan.ready),
      .item_in   (core_result),
      .valid_out (rsp_valid),
      .item_out  (rsp_item)
   );

   // response channel
   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.step_pulse     = rsp_item.step_pulse;
   assign rsp_chan.move_direction = rsp_item.move_direction;
   assign rsp_chan.axis_position  = rsp_item.axis_position;
   assign rsp_chan.axis_length    = rsp_item.axis_length;
   assign rsp_chan.phase          = rsp_item.phase;

endmodule

>>> rtl/lsh_checker.sv
// Port-level checks for the homing sequencer, bound to the top level.
// Depends on lsh_pkg and limit_switch_homing_sequencer_top.
module lsh_checker import lsh_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      step_pulse,
   input logic                      move_direction,
   input logic signed [AXPOS_W-1:0] axis_position,
   input logic [LENGTH_W-1:0]       axis_length,
   input logic [PHASE_W-1:0]        phase
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(axis_position) &&
      $stable(phase) && $stable(step_pulse) && $stable(axis_length))
      else $error("response beat changed while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

   // step pulses only in a moving phase
   a_pulse_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && step_pulse |-> (phase == PH_SEEK_HOME) || (phase == PH_BACK_OFF) ||
      (phase == PH_SEEK_END))
      else $error("step pulse outside a moving phase");

   // seeking home moves toward home, backing off and seeking end move toward end
   a_dir_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((phase == PH_SEEK_HOME) && !move_direction) ||
      ((phase == PH_BACK_OFF) && move_direction) ||
      ((phase == PH_SEEK_END) && move_direction) ||
      (phase == PH_IDLE) || (phase == PH_DONE))
      else $error("direction does not match phase");

   // backing off finishes with the position at zero
   a_home_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid && (phase == PH_DONE) &&
      $past(phase == PH_BACK_OFF) |-> axis_position == '0)
      else $error("position not zero after homing");

endmodule

bind limit_switch_homing_sequencer_top lsh_checker u_lsh_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .step_pulse     (rsp_chan.step_pulse),
   .move_direction (rsp_chan.move_direction),
   .axis_position  (rsp_chan.axis_position),
   .axis_length    (rsp_chan.axis_length),
   .phase          (rsp_chan.phase)
);
